// ----- rtl/utcodr_pkg.sv -----
package utcodr_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 7;
  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned SHIFT_W  = 2;
  localparam int unsigned SUM_W    = 7;

  localparam logic signed [SUM_W-1:0] LAST_HOUR     = 7'sd23;
  localparam logic signed [SUM_W-1:0] HOURS_PER_DAY = 7'sd24;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] FIRST_DAY    = 5'd1;
  localparam logic [DAY_W-1:0] DAYS_LONG    = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT   = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB     = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

  localparam logic [YEAR_W-1:0] YEAR_FIRST = 7'd0;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 7'd99;

  localparam logic [SHIFT_W-1:0] SHIFT_SAME = 2'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_NEXT = 2'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_PREV = 2'd2;

  typedef struct packed {
    logic [HOUR_W-1:0]  utc_hour;
    logic [DAY_W-1:0]   utc_day;
    logic [MONTH_W-1:0] utc_month;
    logic [YEAR_W-1:0]  utc_year;
  } utc_time_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  local_hour;
    logic [DAY_W-1:0]   local_day;
    logic [MONTH_W-1:0] local_month;
    logic [YEAR_W-1:0]  local_year;
    logic [SHIFT_W-1:0] day_shift;
  } local_time_t;

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      MONTH_FEB: len = (year[1:0] == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
      default:   len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/utc_offset_date_rollover.sv -----
// UTC to local time converter with calendar date rollover.
// Input channel in_valid/in_ready/in_data carries one UTC timestamp per item
// (binary hour, day, month, two-digit year). Output channel
// out_valid/out_ready/out_data carries the local time plus a day_shift code
// (0 same day, 1 next day, 2 previous day).
// cfg_wr_en/cfg_wr_data load the signed hour offset; write it only while the
// block holds no item. The offset is applied when an item leaves the input
// register.
// An accepted item passes through two register stages, the input register and
// then the result register, which drives out_data.
// Throughput: one item per cycle while the receiver keeps out_ready high; the
// calendar logic between the two registers is a single short combinational pass.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready drops only when both stages are full.
// Synchronous reset (rst_n low) empties both stages and sets the offset to 0.
module utc_offset_date_rollover
  import utcodr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  utc_time_t                  in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output local_time_t                out_data,
  input  logic                       cfg_wr_en,
  input  logic signed [OFFSET_W-1:0] cfg_wr_data
);

  logic signed [OFFSET_W-1:0] offset_r;
  logic                       s1_valid_r;
  utc_time_t                  s1_data_r;
  logic                       s2_valid_r;
  local_time_t                s2_data_r;
  local_time_t                res_nxt;
  logic                       s1_adv;
  logic                       in_fire;

  assign s1_adv   = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic [DAY_W-1:0]        day;
    logic [MONTH_W-1:0]      month;
    logic [YEAR_W-1:0]       year;
    logic [SHIFT_W-1:0]      shift;
    sum   = $signed({{(SUM_W-HOUR_W){1'b0}}, s1_data_r.utc_hour})
          + $signed({{(SUM_W-OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r});
    day   = s1_data_r.utc_day;
    month = s1_data_r.utc_month;
    year  = s1_data_r.utc_year;
    shift = SHIFT_SAME;
    if (sum > LAST_HOUR) begin
      sum   = sum - HOURS_PER_DAY;
      shift = SHIFT_NEXT;
      if (day >= month_length(month, year)) begin
        day = FIRST_DAY;
        if (month >= MONTH_DEC) begin
          month = MONTH_JAN;
          year  = (year >= YEAR_LAST) ? YEAR_FIRST : year + 7'd1;
        end else begin
          month = month + 4'd1;
        end
      end else begin
        day = day + 5'd1;
      end
    end else if (sum < 0) begin
      sum   = sum + HOURS_PER_DAY;
      shift = SHIFT_PREV;
      if (day <= FIRST_DAY) begin
        if (month <= MONTH_JAN) begin
          month = MONTH_DEC;
          year  = (year == YEAR_FIRST) ? YEAR_LAST : year - 7'd1;
        end else begin
          month = month - 4'd1;
        end
        day = month_length(month, year);
      end else begin
        day = day - 5'd1;
      end
    end
    res_nxt.local_hour  = sum[HOUR_W-1:0];
    res_nxt.local_day   = day;
    res_nxt.local_month = month;
    res_nxt.local_year  = year;
    res_nxt.day_shift   = shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      s2_data_r <= res_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule
